[rtl/mtds_pkg.sv]
// shared fixed-point constants and request kinds for the median tds converter
// no dependencies
package mtds_pkg;
  localparam int unsigned CfgBits = 14;
  localparam int unsigned OutBits = 20;
  localparam logic [CfgBits-1:0] TempReset = 14'd6400;
  localparam logic [17:0] VrefQ16 = 18'd216268;
  localparam logic [23:0] Coef3Q16 = 24'd8743813;
  localparam logic [24:0] Coef2Q16 = 25'd16768000;
  localparam logic [25:0] Coef1Q16 = 26'd56189911;
  localparam logic [18:0] OffsetQ16 = 19'd281804;
  localparam logic [OutBits-1:0] OutMax = 20'hFFFFF;
  // ceil(2^27 / 25): temp * 512 / 100 equals (temp * TempRecip) >> 20 over the 14-bit range
  localparam logic [22:0] TempRecip = 23'd5368710;
  localparam logic KindStore = 1'b0;
  localparam logic KindRead = 1'b1;
endpackage

[rtl/mtds_divider.sv]
// restoring divider, one quotient bit per cycle, quotient 19 bits
// depends on nothing; operands are q16 voltage and q16 coefficient
module mtds_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [18:0] quot_o
);
  logic [33:0] num_q, num_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [18:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] trial;
  logic [18:0] shifted;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    quot_d = quot_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, num_q[33]};
    trial = shifted - {2'b0, den_q};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      quot_d = '0;
      cnt_d = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[32:0], 1'b0};
      if (!trial[18]) begin
        rem_d = trial[17:0];
        quot_d = {quot_q[17:0], 1'b1};
      end else begin
        rem_d = shifted[17:0];
        quot_d = {quot_q[17:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

[rtl/median_tds_converter.sv]
// median tds converter top level: sample ring memory, rank-count median, tds arithmetic
// depends on mtds_pkg and mtds_divider
// a store request is written to the ring when it is accepted; a read request runs the rank count,
// which reads the ring once per compare, and then the 34-step divider. one request at a time; a
// finished result sits in the output register while the next store request is taken. after reset
// the ring is cleared one entry a cycle, and no request is taken until every entry is cleared
module median_tds_converter #(
  parameter int unsigned WINDOW = 30,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // adc_sample[11:0]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tds_ppm_q4[19:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mtds_pkg::CfgBits-1:0] cfg_data_i
);
  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [CntW-1:0] Last = CntW'(WINDOW - 1);
  localparam logic [CntW-1:0] Count = CntW'(WINDOW);
  localparam logic [CntW-1:0] RankLo = CntW'((WINDOW - 1) / 2);
  localparam logic [CntW-1:0] RankHi = CntW'(WINDOW / 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OUTER, S_INNER, S_MED, S_VOLT, S_DIVGO, S_DIV,
    S_SQ, S_CUBE, S_TERMS, S_SUM, S_OUT
  } state_e;

  state_e state_q;
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] wslot_q, i_q, j_q, less_q, eq_q;
  logic [SAMPLE_BITS-1:0] key_q, lo_q, hi_q;
  logic            key_ld_q;
  logic [mtds_pkg::CfgBits-1:0] temp_q;
  logic [47:0] a_q, b_q, c_q;
  logic [16:0] coef_q;
  logic [18:0] v_q;
  logic        div_start;
  logic        div_done;
  logic [18:0] div_quot;
  logic [mtds_pkg::OutBits-1:0] out_q;
  logic        ovalid_q;
  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic        in_fire;
  logic [CntW:0] cnt_le;
  logic [CntW:0] cnt_lt;
  logic [48:0] sum;
  logic [47:0] pos_w;

  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || s_axis_tuser == mtds_pkg::KindStore);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'b0, out_q};
  assign div_start = (state_q == S_DIVGO);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = wslot_q[IdxW-1:0];
    wr_data = s_axis_tdata[SAMPLE_BITS-1:0];
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (in_fire && s_axis_tuser == mtds_pkg::KindStore) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = (state_q == S_INNER && j_q != Count) ? j_q[IdxW-1:0] : i_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[wr_addr] <= wr_data;
    rd_data_q <= ring_mem[rd_addr];
  end

  mtds_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i({a_q[17:0], 16'b0}), .den_i(coef_q),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign cnt_le = {1'b0, less_q} + {1'b0, eq_q};
  assign cnt_lt = {1'b0, less_q};
  assign pos_w = a_q + c_q;
  assign sum = {1'b0, pos_w} - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      wslot_q <= '0;
      temp_q <= mtds_pkg::TempReset;
      ovalid_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      key_ld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) temp_q <= cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (wslot_q == Last) begin
            wslot_q <= '0;
            state_q <= S_IDLE;
          end else begin
            wslot_q <= wslot_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == mtds_pkg::KindStore) begin
              wslot_q <= (wslot_q == Last) ? '0 : wslot_q + 1'b1;
            end else begin
              i_q <= '0;
              key_ld_q <= 1'b0;
              state_q <= S_OUTER;
            end
          end
        end
        S_OUTER: begin
          if (!key_ld_q) begin
            key_ld_q <= 1'b1;
          end else begin
            key_q <= rd_data_q;
            key_ld_q <= 1'b0;
            less_q <= '0;
            eq_q <= '0;
            j_q <= '0;
            state_q <= S_INNER;
          end
        end
        S_INNER: begin
          // the registered read data belongs to the address of the previous cycle
          if (j_q != '0) begin
            if (rd_data_q < key_q) less_q <= less_q + 1'b1;
            else if (rd_data_q == key_q) eq_q <= eq_q + 1'b1;
          end
          if (j_q == Count) state_q <= S_MED;
          else j_q <= j_q + 1'b1;
        end
        S_MED: begin
          if (cnt_lt <= {1'b0, RankLo} && cnt_le > {1'b0, RankLo}) lo_q <= key_q;
          if (cnt_lt <= {1'b0, RankHi} && cnt_le > {1'b0, RankHi}) hi_q <= key_q;
          if (i_q == Last) begin
            state_q <= S_VOLT;
          end else begin
            i_q <= i_q + 1'b1;
            key_ld_q <= 1'b0;
            state_q <= S_OUTER;
          end
        end
        S_VOLT: begin
          state_q <= S_DIVGO;
        end
        S_DIVGO: state_q <= S_DIV;
        S_DIV: if (div_done) state_q <= S_SQ;
        S_SQ: state_q <= S_CUBE;
        S_CUBE: state_q <= S_TERMS;
        S_TERMS: state_q <= S_SUM;
        S_SUM: state_q <= S_OUT;
        S_OUT: begin
          ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath, one stage per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_VOLT: begin
        a_q <= 48'(({{(17 - SAMPLE_BITS){1'b0}}, lo_q} + {{(17 - SAMPLE_BITS){1'b0}}, hi_q}) >> 1)
               * 48'(mtds_pkg::VrefQ16) >> 12;
        coef_q <= 17'd32768 + 17'((37'(temp_q) * 37'(mtds_pkg::TempRecip)) >> 20);
      end
      S_DIV: if (div_done) v_q <= div_quot;
      S_SQ: b_q <= (48'(v_q) * 48'(v_q)) >> 16;
      S_CUBE: c_q <= (b_q * 48'(v_q)) >> 16;
      S_TERMS: begin
        a_q <= (48'(mtds_pkg::Coef3Q16) * c_q) >> 16;
        b_q <= (48'(mtds_pkg::Coef2Q16) * b_q) >> 16;
        c_q <= (48'(mtds_pkg::Coef1Q16) * 48'(v_q)) >> 16;
      end
      S_SUM: begin
        if (pos_w <= b_q) a_q <= '0;
        else a_q <= sum[48:1];
      end
      S_OUT: begin
        if (a_q <= 48'(mtds_pkg::OffsetQ16)) out_q <= '0;
        else if (((a_q - 48'(mtds_pkg::OffsetQ16)) >> 12) > 48'(mtds_pkg::OutMax))
          out_q <= mtds_pkg::OutMax;
        else out_q <= 20'((a_q - 48'(mtds_pkg::OffsetQ16)) >> 12);
      end
      default: ;
    endcase
  end
endmodule

[dv/mtds_checker.sv]
// checker for the median tds converter: watches the sample, result and config channels
// keeps its own sample ring and temperature, predicts each reading and compares
// depends on mtds_pkg
`timescale 1ns / 1ps
module mtds_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // adc_sample[11:0]
  input  logic        s_axis_tuser,  // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // tds_ppm_q4[19:0]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [mtds_pkg::CfgBits-1:0] cfg_data_i,
  output int          mismatch_cnt,
  output int          readings_waiting,
  output int          readings_seen,
  output int          samples_seen
);
  localparam int Window = 30;

  logic [11:0]                  ring [Window];
  int                           slot;
  logic [mtds_pkg::CfgBits-1:0] temp_q8;
  logic [19:0]                  tds_expected [$];

  function automatic logic [19:0] tds_of_ring(input logic [mtds_pkg::CfgBits-1:0] temp);
    logic [11:0] s [Window];
    logic [11:0] key;
    logic [63:0] m, u, c, v, v2, v3, t3, t2, t1, pos, h, r;
    int j;
    s = ring;
    for (int i = 1; i < Window; i++) begin
      key = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = key;
    end
    m = (64'(s[Window/2]) + 64'(s[Window/2-1])) >> 1;
    u = (m * 64'(mtds_pkg::VrefQ16)) >> 12;
    c = 64'd32768 + (64'(temp) * 64'd512) / 64'd100;
    v = (u << 16) / c;
    v2 = (v * v) >> 16;
    v3 = (v2 * v) >> 16;
    t3 = (64'(mtds_pkg::Coef3Q16) * v3) >> 16;
    t2 = (64'(mtds_pkg::Coef2Q16) * v2) >> 16;
    t1 = (64'(mtds_pkg::Coef1Q16) * v) >> 16;
    pos = t3 + t1;
    if (pos <= t2) return '0;
    h = (pos - t2) >> 1;
    if (h <= 64'(mtds_pkg::OffsetQ16)) return '0;
    r = (h - 64'(mtds_pkg::OffsetQ16)) >> 12;
    return (r > 64'(mtds_pkg::OutMax)) ? mtds_pkg::OutMax : r[19:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ring[i]) ring[i] = '0;
      slot = 0;
      temp_q8 = mtds_pkg::TempReset;
      tds_expected.delete();
      mismatch_cnt = 0;
      readings_seen = 0;
      samples_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) temp_q8 = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        readings_seen++;
        if (tds_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected reading %0d", $time, m_axis_tdata[19:0]);
        end else if (m_axis_tdata[19:0] !== tds_expected[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: tds_ppm_q4 expected %0d got %0d", $time, tds_expected[0],
                     m_axis_tdata[19:0]);
          void'(tds_expected.pop_front());
        end else begin
          void'(tds_expected.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == mtds_pkg::KindRead) begin
          tds_expected.push_back(tds_of_ring(temp_q8));
        end else begin
          samples_seen++;
          ring[slot] = s_axis_tdata[11:0];
          slot = (slot == Window - 1) ? 0 : slot + 1;
        end
      end
    end
    readings_waiting = tds_expected.size();
  end
endmodule

[dv/tb_median_tds_converter.sv]
// stimulus and verdict for the median tds converter
// drives samples, readings and temperature settings; checking is done in mtds_checker
// depends on mtds_pkg, median_tds_converter and mtds_checker
`timescale 1ns / 1ps
module tb_median_tds_converter;
  localparam int Settle = 1200;
  localparam int CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = mtds_pkg::KindStore;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [mtds_pkg::CfgBits-1:0] cfg_data_i = '0;

  int mismatch_cnt, readings_waiting, readings_seen, samples_seen;
  int cycle_cnt = 0;
  int ready_hold = 0;
  bit no_idle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  median_tds_converter uut (.*);

  mtds_checker u_checker (.*);

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      m_axis_tready = no_idle ? 1'b1 : ($urandom_range(3) != 0);
      ready_hold = m_axis_tready ? $urandom_range(0, 6) : gap_len();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input logic [11:0] adc);
    repeat (gap_len()) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {4'b0, adc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_temp(input logic [mtds_pkg::CfgBits-1:0] temp);
    while (readings_waiting != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = temp;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_phase(input int count);
    int mode;
    logic [11:0] base;
    mode = $urandom_range(3);
    base = 12'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0) begin
        send_request(mtds_pkg::KindRead, 12'($urandom));
      end else begin
        case (mode)
          0: send_request(mtds_pkg::KindStore, 12'($urandom));
          1: send_request(mtds_pkg::KindStore, base + 12'($urandom_range(0, 63)));
          2: send_request(mtds_pkg::KindStore,
                          $urandom_range(1) ? 12'hFFF : 12'($urandom_range(0, 40)));
          default: send_request(mtds_pkg::KindStore, 12'($urandom_range(0, 300)));
        endcase
      end
    end
  endtask

  logic [mtds_pkg::CfgBits-1:0] temps [5];

  initial begin
    temps = '{14'd0, 14'd12800, 14'h3FFF, 14'd6400, 14'd0};
    temps[4] = 14'($urandom_range(0, 12800));
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: read of the cleared ring, full scale, small values, ignored sample bits
    send_request(mtds_pkg::KindRead, 12'hFFF);
    write_temp(14'd6400);
    for (int i = 0; i < 15; i++) send_request(mtds_pkg::KindStore, 12'hFFF);
    send_request(mtds_pkg::KindRead, 12'h000);
    for (int i = 0; i < 2; i++) send_request(mtds_pkg::KindStore, 12'd3);
    send_request(mtds_pkg::KindRead, 12'hA5A);
    for (int i = 0; i < 3; i++) send_request(mtds_pkg::KindStore, 12'hFFF);
    send_request(mtds_pkg::KindRead, 12'h5A5);
    write_temp(14'd0);
    send_request(mtds_pkg::KindRead, 12'd0);

    for (int p = 0; p < 5; p++) begin
      write_temp(temps[p]);
      no_idle = (p == 2);
      random_phase(90);
    end
    no_idle = 1'b0;

    while (readings_waiting != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
    $display("sent %0d samples, checked %0d readings over 7 temperature settings",
             samples_seen, readings_seen);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/mtds_pkg.sv
rtl/mtds_divider.sv
rtl/median_tds_converter.sv
dv/mtds_checker.sv
dv/tb_median_tds_converter.sv
